// ----- src/assert_macros.svh -----
// Assertion macros used by the checker module rga_checker.
// No dependencies; each macro takes its clock and active-low reset explicitly.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rga_pkg.sv -----
// Shared constants for the radial glow alpha pipeline.
// No dependencies; used by radial_glow_alpha_top and rga_checker.
package rga_pkg;

    // Field and register widths
    localparam int MAX_SIDE   = 256;
    localparam int COORD_W    = 8;
    localparam int SIDE_W     = 9;
    localparam int FRAC_W     = 17;
    localparam int FRAC_BITS  = 16;
    localparam int ALPHA_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = FRAC_W;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PLATEAU = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE    = CFG_IDX_W'(2);

    // Reset values
    localparam logic [SIDE_W-1:0] SIDE_RST    = SIDE_W'(64);
    localparam logic [FRAC_W-1:0] PLATEAU_RST = FRAC_W'(16384);
    localparam logic [FRAC_W-1:0] EDGE_RST    = FRAC_W'(62259);

    localparam logic [ALPHA_W-1:0] ALPHA_MAX = {ALPHA_W{1'b1}};

    // Datapath widths
    localparam int MAG_W     = SIDE_W;                 // |2x+1-side|
    localparam int SQ_W      = 2 * MAG_W;
    localparam int SUM_W     = SQ_W + 1;
    localparam int SUM_PAIRS = (SUM_W + 1) / 2;
    localparam int PAD_W     = 2 * SUM_PAIRS;
    localparam int ROOT_W    = SUM_PAIRS + FRAC_BITS;  // sqrt(sum << 32)
    localparam int REM_W     = ROOT_W + 2;
    localparam int QUO_W     = FRAC_W;                 // radius, < 2^17
    localparam int NUM_W     = 3 * FRAC_W + 2;
    localparam int DEN_W     = 3 * FRAC_W;
    localparam int SCL_W     = NUM_W + ALPHA_W;

    // mag, sum, root steps, divide steps, poly, product, scale,
    // alpha quotient steps, output register
    localparam int PIPE_DEPTH = 2 + ROOT_W + QUO_W + 3 + ALPHA_W + 1;

endpackage

// ----- src/radial_glow_alpha_top.sv -----
// Radial glow alpha: pixel coordinate in, 8-bit smoothstep alpha out.
// Depends on rga_pkg.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    col, row_index
// out      output     out_valid / out_ready  alpha
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction per cycle sustained while the output is not stalled.
// The depth is set by the 26-step square root and the 17-step divide by the
// side, one result bit per stage, plus eight stages of alpha quotient.
// Reset clears the valid bits and loads default configuration.
// A stalled output freezes every stage; an empty entry stage still takes
// one transaction while the output waits.
module radial_glow_alpha_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [rga_pkg::COORD_W-1:0]     col,
    input  logic [rga_pkg::COORD_W-1:0]     row_index,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [rga_pkg::ALPHA_W-1:0]     alpha,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rga_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rga_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers
    logic [rga_pkg::SIDE_W-1:0] side_reg;
    logic [rga_pkg::FRAC_W-1:0] plateau_reg;
    logic [rga_pkg::FRAC_W-1:0] edge_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg    <= rga_pkg::SIDE_RST;
            plateau_reg <= rga_pkg::PLATEAU_RST;
            edge_reg    <= rga_pkg::EDGE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rga_pkg::CFG_SIDE:    side_reg    <= cfg_data[rga_pkg::SIDE_W-1:0];
                rga_pkg::CFG_PLATEAU: plateau_reg <= cfg_data[rga_pkg::FRAC_W-1:0];
                rga_pkg::CFG_EDGE:    edge_reg    <= cfg_data[rga_pkg::FRAC_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective side, clamped to 1..MAX_SIDE
    logic [rga_pkg::SIDE_W-1:0] side_eff;
    logic [rga_pkg::SIDE_W-1:0] side_m1;

    always_comb
    begin
        priority if (side_reg == '0)
            side_eff = rga_pkg::SIDE_W'(1);
        else if (32'(side_reg) > rga_pkg::MAX_SIDE)
            side_eff = rga_pkg::SIDE_W'(rga_pkg::MAX_SIDE);
        else
            side_eff = side_reg;
    end

    assign side_m1 = side_eff - rga_pkg::SIDE_W'(1);

    // Pipeline flow control
    logic [rga_pkg::PIPE_DEPTH-1:0] vld_reg;
    logic adv;
    logic en_in;

    assign adv       = !vld_reg[rga_pkg::PIPE_DEPTH-1] || out_ready;
    assign en_in     = adv || !vld_reg[0];
    assign in_ready  = en_in;
    assign out_valid = vld_reg[rga_pkg::PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en_in)
                vld_reg[0] <= in_valid;
            if (adv)
                vld_reg[rga_pkg::PIPE_DEPTH-1:1] <= vld_reg[rga_pkg::PIPE_DEPTH-2:0];
        end
    end

    // Distance of a saturated coordinate's pixel centre from the picture centre,
    // in half pixels
    function automatic logic [rga_pkg::MAG_W-1:0] offset_mag(
        input logic [rga_pkg::COORD_W-1:0] pos,
        input logic [rga_pkg::SIDE_W-1:0]  side,
        input logic [rga_pkg::SIDE_W-1:0]  lim
    );
        logic [rga_pkg::SIDE_W:0] p_ext;
        logic [rga_pkg::SIDE_W:0] twice;
        logic [rga_pkg::SIDE_W:0] s_ext;
        p_ext = (rga_pkg::SIDE_W+1)'(pos);
        if (p_ext > {1'b0, lim})
            p_ext = {1'b0, lim};
        twice = {p_ext[rga_pkg::SIDE_W-1:0], 1'b1};
        s_ext = {1'b0, side};
        if (twice >= s_ext)
            return rga_pkg::MAG_W'(twice - s_ext);
        else
            return rga_pkg::MAG_W'(s_ext - twice);
    endfunction

    // Stage: centre offsets
    logic [rga_pkg::MAG_W-1:0] mag_x_reg;
    logic [rga_pkg::MAG_W-1:0] mag_y_reg;

    always_ff @(posedge clk)
    begin
        if (en_in)
        begin
            mag_x_reg <= offset_mag(col, side_eff, side_m1);
            mag_y_reg <= offset_mag(row_index, side_eff, side_m1);
        end
    end

    // Stage: sum of squares
    logic [rga_pkg::SQ_W-1:0]  sq_x;
    logic [rga_pkg::SQ_W-1:0]  sq_y;
    logic [rga_pkg::SUM_W-1:0] sum_reg;

    assign sq_x = rga_pkg::SQ_W'(mag_x_reg) * rga_pkg::SQ_W'(mag_x_reg);
    assign sq_y = rga_pkg::SQ_W'(mag_y_reg) * rga_pkg::SQ_W'(mag_y_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
            sum_reg <= {1'b0, sq_x} + {1'b0, sq_y};
    end

    // Square root of sum << 32, one root bit per stage.
    // Radicand pairs shift out of the top of rt_bits; zeros follow.
    logic [rga_pkg::PAD_W-1:0]  rt_bits_in  [rga_pkg::ROOT_W];
    logic [rga_pkg::ROOT_W-1:0] rt_root_in  [rga_pkg::ROOT_W];
    logic [rga_pkg::REM_W-1:0]  rt_rem_in   [rga_pkg::ROOT_W];
    logic [rga_pkg::PAD_W-1:0]  rt_bits_next[rga_pkg::ROOT_W];
    logic [rga_pkg::ROOT_W-1:0] rt_root_next[rga_pkg::ROOT_W];
    logic [rga_pkg::REM_W-1:0]  rt_rem_next [rga_pkg::ROOT_W];
    logic [rga_pkg::PAD_W-1:0]  rt_bits_reg [rga_pkg::ROOT_W];
    logic [rga_pkg::ROOT_W-1:0] rt_root_reg [rga_pkg::ROOT_W];
    logic [rga_pkg::REM_W-1:0]  rt_rem_reg  [rga_pkg::ROOT_W];

    always_comb
    begin
        rt_bits_in[0] = rga_pkg::PAD_W'(sum_reg);
        rt_root_in[0] = '0;
        rt_rem_in[0]  = '0;
        for (int k = 1; k < rga_pkg::ROOT_W; k++)
        begin
            rt_bits_in[k] = rt_bits_reg[k-1];
            rt_root_in[k] = rt_root_reg[k-1];
            rt_rem_in[k]  = rt_rem_reg[k-1];
        end
        for (int k = 0; k < rga_pkg::ROOT_W; k++)
        begin
            logic [rga_pkg::REM_W-1:0] tr;
            logic [rga_pkg::REM_W-1:0] trial;
            logic ge;
            tr    = {rt_rem_in[k][rga_pkg::REM_W-3:0],
                     rt_bits_in[k][rga_pkg::PAD_W-1 -: 2]};
            trial = {rt_root_in[k], 2'b01};
            ge    = (tr >= trial);
            rt_bits_next[k] = {rt_bits_in[k][rga_pkg::PAD_W-3:0], 2'b00};
            rt_root_next[k] = {rt_root_in[k][rga_pkg::ROOT_W-2:0], ge};
            rt_rem_next[k]  = ge ? (tr - trial) : tr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < rga_pkg::ROOT_W; k++)
            begin
                rt_bits_reg[k] <= rt_bits_next[k];
                rt_root_reg[k] <= rt_root_next[k];
                rt_rem_reg[k]  <= rt_rem_next[k];
            end
        end
    end

    // Radius = root / side, restoring divide, one quotient bit per stage.
    // The low dividend bits shift out while quotient bits shift in.
    logic [rga_pkg::SIDE_W-1:0] dv_rem_in  [rga_pkg::QUO_W];
    logic [rga_pkg::QUO_W-1:0]  dv_lo_in   [rga_pkg::QUO_W];
    logic [rga_pkg::SIDE_W-1:0] dv_rem_next[rga_pkg::QUO_W];
    logic [rga_pkg::QUO_W-1:0]  dv_lo_next [rga_pkg::QUO_W];
    logic [rga_pkg::SIDE_W-1:0] dv_rem_reg [rga_pkg::QUO_W];
    logic [rga_pkg::QUO_W-1:0]  dv_lo_reg  [rga_pkg::QUO_W];

    always_comb
    begin
        // radius < 2^17, so the high root bits are already below side
        dv_rem_in[0] = rga_pkg::SIDE_W'(rt_root_reg[rga_pkg::ROOT_W-1] >> rga_pkg::QUO_W);
        dv_lo_in[0]  = rt_root_reg[rga_pkg::ROOT_W-1][rga_pkg::QUO_W-1:0];
        for (int j = 1; j < rga_pkg::QUO_W; j++)
        begin
            dv_rem_in[j] = dv_rem_reg[j-1];
            dv_lo_in[j]  = dv_lo_reg[j-1];
        end
        for (int j = 0; j < rga_pkg::QUO_W; j++)
        begin
            logic [rga_pkg::SIDE_W:0] t;
            logic ge;
            t  = {dv_rem_in[j], dv_lo_in[j][rga_pkg::QUO_W-1]};
            ge = (t >= {1'b0, side_eff});
            dv_rem_next[j] = ge ? rga_pkg::SIDE_W'(t - {1'b0, side_eff})
                                : rga_pkg::SIDE_W'(t);
            dv_lo_next[j]  = {dv_lo_in[j][rga_pkg::QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < rga_pkg::QUO_W; j++)
            begin
                dv_rem_reg[j] <= dv_rem_next[j];
                dv_lo_reg[j]  <= dv_lo_next[j];
            end
        end
    end

    // Stage: region flags and smoothstep terms
    logic [rga_pkg::QUO_W-1:0]    radius;
    logic [rga_pkg::FRAC_W-1:0]   span_d;
    logic [rga_pkg::FRAC_W-1:0]   off_n;
    logic [rga_pkg::FRAC_W-1:0]   rest_m;
    logic                         pl_zero_reg;
    logic                         pl_full_reg;
    logic [2*rga_pkg::FRAC_W-1:0] pl_m2_reg;
    logic [2*rga_pkg::FRAC_W-1:0] pl_d2_reg;
    logic [rga_pkg::FRAC_W+1:0]   pl_t_reg;
    logic [rga_pkg::FRAC_W-1:0]   pl_d_reg;

    assign radius = dv_lo_reg[rga_pkg::QUO_W-1];
    assign span_d = edge_reg - plateau_reg;
    assign off_n  = radius - plateau_reg;
    assign rest_m = edge_reg - radius;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pl_zero_reg <= (radius >= edge_reg);
            pl_full_reg <= (radius <= plateau_reg);
            pl_m2_reg   <= (2*rga_pkg::FRAC_W)'(rest_m) * (2*rga_pkg::FRAC_W)'(rest_m);
            pl_d2_reg   <= (2*rga_pkg::FRAC_W)'(span_d) * (2*rga_pkg::FRAC_W)'(span_d);
            pl_t_reg    <= {2'b00, span_d} + {1'b0, off_n, 1'b0};
            pl_d_reg    <= span_d;
        end
    end

    // Stage: numerator (d-n)^2 (d+2n) and denominator d^3
    logic                       pr_zero_reg;
    logic                       pr_full_reg;
    logic [rga_pkg::NUM_W-1:0]  pr_num_reg;
    logic [rga_pkg::DEN_W-1:0]  pr_den_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr_zero_reg <= pl_zero_reg;
            pr_full_reg <= pl_full_reg;
            pr_num_reg  <= rga_pkg::NUM_W'(pl_m2_reg) * rga_pkg::NUM_W'(pl_t_reg);
            pr_den_reg  <= rga_pkg::DEN_W'(pl_d2_reg) * rga_pkg::DEN_W'(pl_d_reg);
        end
    end

    // Stage: scale numerator by 255
    logic                       sc_zero_reg;
    logic                       sc_full_reg;
    logic [rga_pkg::SCL_W-1:0]  sc_n_reg;
    logic [rga_pkg::DEN_W-1:0]  sc_den_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sc_zero_reg <= pr_zero_reg;
            sc_full_reg <= pr_full_reg;
            sc_n_reg    <= (rga_pkg::SCL_W'(pr_num_reg) << rga_pkg::ALPHA_W)
                         - rga_pkg::SCL_W'(pr_num_reg);
            sc_den_reg  <= pr_den_reg;
        end
    end

    // Alpha quotient, MSB first; the scaled numerator is below 256 * den
    logic [rga_pkg::SCL_W-1:0]   qt_rem_in  [rga_pkg::ALPHA_W];
    logic [rga_pkg::ALPHA_W-1:0] qt_q_in    [rga_pkg::ALPHA_W];
    logic [rga_pkg::DEN_W-1:0]   qt_den_in  [rga_pkg::ALPHA_W];
    logic                        qt_zero_in [rga_pkg::ALPHA_W];
    logic                        qt_full_in [rga_pkg::ALPHA_W];
    logic [rga_pkg::SCL_W-1:0]   qt_rem_next[rga_pkg::ALPHA_W];
    logic [rga_pkg::ALPHA_W-1:0] qt_q_next  [rga_pkg::ALPHA_W];
    logic [rga_pkg::SCL_W-1:0]   qt_rem_reg [rga_pkg::ALPHA_W];
    logic [rga_pkg::ALPHA_W-1:0] qt_q_reg   [rga_pkg::ALPHA_W];
    logic [rga_pkg::DEN_W-1:0]   qt_den_reg [rga_pkg::ALPHA_W];
    logic                        qt_zero_reg[rga_pkg::ALPHA_W];
    logic                        qt_full_reg[rga_pkg::ALPHA_W];

    always_comb
    begin
        qt_rem_in[0]  = sc_n_reg;
        qt_q_in[0]    = '0;
        qt_den_in[0]  = sc_den_reg;
        qt_zero_in[0] = sc_zero_reg;
        qt_full_in[0] = sc_full_reg;
        for (int k = 1; k < rga_pkg::ALPHA_W; k++)
        begin
            qt_rem_in[k]  = qt_rem_reg[k-1];
            qt_q_in[k]    = qt_q_reg[k-1];
            qt_den_in[k]  = qt_den_reg[k-1];
            qt_zero_in[k] = qt_zero_reg[k-1];
            qt_full_in[k] = qt_full_reg[k-1];
        end
        for (int k = 0; k < rga_pkg::ALPHA_W; k++)
        begin
            logic [rga_pkg::SCL_W-1:0] dsh;
            logic ge;
            dsh = rga_pkg::SCL_W'(qt_den_in[k]) << (rga_pkg::ALPHA_W - 1 - k);
            ge  = (qt_rem_in[k] >= dsh);
            qt_rem_next[k] = ge ? (qt_rem_in[k] - dsh) : qt_rem_in[k];
            qt_q_next[k]   = {qt_q_in[k][rga_pkg::ALPHA_W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < rga_pkg::ALPHA_W; k++)
            begin
                qt_rem_reg[k]  <= qt_rem_next[k];
                qt_q_reg[k]    <= qt_q_next[k];
                qt_den_reg[k]  <= qt_den_in[k];
                qt_zero_reg[k] <= qt_zero_in[k];
                qt_full_reg[k] <= qt_full_in[k];
            end
        end
    end

    // Output register: edge test first, then plateau, else smoothstep
    logic [rga_pkg::ALPHA_W-1:0] alpha_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            priority if (qt_zero_reg[rga_pkg::ALPHA_W-1])
                alpha_reg <= '0;
            else if (qt_full_reg[rga_pkg::ALPHA_W-1])
                alpha_reg <= rga_pkg::ALPHA_MAX;
            else
                alpha_reg <= qt_q_reg[rga_pkg::ALPHA_W-1];
        end
    end

    assign alpha = alpha_reg;

endmodule

// ----- src/rga_checker.sv -----
// Port-level checker for radial_glow_alpha_top, bound to the top level.
// Depends on rga_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rga_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [rga_pkg::ALPHA_W-1:0] alpha
);

    localparam int CNT_W = $clog2(rga_pkg::PIPE_DEPTH + 1);

    // Transactions accepted but not yet delivered
    logic [CNT_W-1:0] inflight_reg;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
        begin
            unique case ({in_acc, out_acc})
                2'b10:   inflight_reg <= inflight_reg + CNT_W'(1);
                2'b01:   inflight_reg <= inflight_reg - CNT_W'(1);
                default: inflight_reg <= inflight_reg;
            endcase
        end
    end

    // Stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(alpha), "stalled result changed")

    // A result only for an accepted transaction
    `ASSERT_IMPLY(a_no_spurious, clk, rst_n, out_valid, inflight_reg != '0, "result without a pending transaction")

    // Never more in flight than pipeline stages
    `ASSERT_ALWAYS(a_inflight_bound, clk, rst_n, inflight_reg <= CNT_W'(rga_pkg::PIPE_DEPTH), "more transactions in flight than stages")

    // Input back-pressure only from a stalled output
    `ASSERT_IMPLY(a_ready_stall, clk, rst_n, !in_ready, out_valid && !out_ready, "input stalled without output stall")

endmodule

bind radial_glow_alpha_top rga_checker u_rga_checker (.*);
